// ===== hw/rtl/asa_pkg.sv =====
// ----------------------------------------------------------------------------
// asa_pkg
// Shared constants, register and mode codes, and the sequencer state type
// of the ADC sample averager.
// ----------------------------------------------------------------------------
package asa_pkg;

    // Channel field widths
    localparam int MODE_W     = 2;
    localparam int SRC_W      = 2;
    localparam int MV_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Per-source state widths
    localparam int CNT_W    = 8;
    localparam int AVG_W    = 16;
    localparam int AVG_FRAC = 4;
    localparam int SUM_FRAC = 8;

    // Configuration
    localparam int EN_W      = 4;
    localparam int NUM_GAINS = 4;
    localparam int GAIN_W    = 24;
    localparam int GIDX_W    = 2;
    localparam int MV_SHIFT  = 20;

    localparam logic [CNT_W-1:0] ROLL_COUNT = 8'd254;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_0        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_3        = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_STORE,
        S_MUL_AVG,
        S_MUL_LAT,
        S_DONE
    } asa_state_t;

endpackage

// ===== hw/rtl/asa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// asa_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface asa_cfg_if import asa_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/asa_in_if.sv =====
// ----------------------------------------------------------------------------
// asa_in_if
// Item channel: one word carries a mode, a source index and a raw sample.
// ----------------------------------------------------------------------------
interface asa_in_if import asa_pkg::*; #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [SRC_W-1:0]       source_idx;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode, output source_idx, output sample, input ready);
    modport sink   (input valid, input mode, input source_idx, input sample, output ready);
endinterface

// ===== hw/rtl/asa_out_if.sv =====
// ----------------------------------------------------------------------------
// asa_out_if
// Result channel: one word per item with the source's sample, average and
// millivolt readings.
// ----------------------------------------------------------------------------
interface asa_out_if import asa_pkg::*; #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SRC_W-1:0]       source_out;
    logic                   attached;
    logic [SAMPLE_BITS-1:0] latest_sample;
    logic [AVG_W-1:0]       average;
    logic [MV_W-1:0]        average_mv;
    logic [MV_W-1:0]        latest_mv;
    logic                   fresh;

    modport source (output valid, output source_out, output attached, output latest_sample,
                    output average, output average_mv, output latest_mv, output fresh,
                    input ready);
    modport sink   (input valid, input source_out, input attached, input latest_sample,
                    input average, input average_mv, input latest_mv, input fresh,
                    output ready);
endinterface

// ===== hw/rtl/asa_divider.sv =====
// ----------------------------------------------------------------------------
// asa_divider
// Restoring unsigned divider, one quotient bit per cycle. done is high in
// the cycle of the last step; quotient holds until the next start.
// ----------------------------------------------------------------------------
module asa_divider #(
    parameter int N = 28,
    parameter int D = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);
    localparam int STEP_W = (N > 1) ? $clog2(N) : 1;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [N-1:0]      quo_reg, quo_next;
    logic [D-1:0]      rem_reg, rem_next;
    logic [D-1:0]      div_reg, div_next;
    logic [D:0]        rem_shift;
    logic [D:0]        diff;
    logic              ge;

    assign rem_shift = {rem_reg, quo_reg[N-1]};
    assign diff      = rem_shift - {1'b0, div_reg};
    assign ge        = rem_shift >= {1'b0, div_reg};
    assign done      = busy_reg && (step_reg == STEP_W'(N - 1));
    assign quotient  = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[N-2:0], ge};
            rem_next  = ge ? diff[D-1:0] : rem_shift[D-1:0];
            step_next = step_reg + STEP_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ===== hw/rtl/adc_sample_averager_core.sv =====
// ----------------------------------------------------------------------------
// adc_sample_averager_core
// Per-source ADC accumulator: latest sample, rolling sum and count, and a
// held average with millivolt conversion, kept in one state memory.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (index 0 source enable, 1..4 gain per source);
//            always ready; the user must write it only while the block is idle, unenforced.
//   item   - one word per item: mode (sample, read and clear, clear source),
//            source index and raw sample.
//   result - one word per item, with the state of the source after the item.
// Each item is a read-modify-write of the source's entry in the state memory
// followed by two passes through the gain multiplier.
// Sequence: an accepted item steps through fetch, the average and latest
// multiplier passes and done, where the result word is registered; the next
// item is taken back in idle. A read that finds samples adds the serial
// divider, one quotient bit a cycle over the 28-bit sum, and a store step.
// A new item is taken while a result word still waits; a stalled receiver
// holds the block only when the following result is ready to go out.
// Reset clears the control and configuration registers and the entry valid
// bits, so every source reads zero at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module adc_sample_averager_core import asa_pkg::*; #(
    parameter int NUM_SOURCES = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    asa_cfg_if.sink    cfg,
    asa_in_if.sink     item,
    asa_out_if.source  result
);
    localparam int IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SUM_W   = SAMPLE_BITS + SUM_FRAC + CNT_W;
    localparam int DIVR_W  = CNT_W + SUM_FRAC - AVG_FRAC;
    localparam int ENT_W   = SAMPLE_BITS + SUM_W + CNT_W + AVG_W;
    localparam int LATX_W  = SAMPLE_BITS + AVG_FRAC;
    localparam int MULA_W  = (LATX_W > AVG_W) ? LATX_W : AVG_W;
    localparam int PROD_W  = MULA_W + GAIN_W;

    // Configuration registers
    logic [EN_W-1:0]   enable_reg;
    logic [GAIN_W-1:0] gain_reg [NUM_GAINS];
    logic [GIDX_W-1:0] cfg_gidx;

    // Sequencer and item
    asa_state_t             state_reg, state_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [SRC_W-1:0]       src_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   on_reg;
    logic                   vidx_reg;
    logic                   item_acc;
    logic                   item_vidx;

    // State memory
    logic [ENT_W-1:0]       mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] ent_valid_reg;
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   rd_hit_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENT_W-1:0]       mem_wdata;

    // Working entry
    logic [SAMPLE_BITS-1:0] lat_reg, lat_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [AVG_W-1:0]       held_reg, held_next;
    logic                   fresh_reg, fresh_next;

    logic [SAMPLE_BITS-1:0] cur_lat;
    logic [SUM_W-1:0]       cur_sum;
    logic [CNT_W-1:0]       cur_cnt;
    logic [AVG_W-1:0]       cur_held;
    logic [SUM_W-1:0]       sum_add;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   roll;

    // Divider
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic [AVG_W-1:0]  quo_sat;

    // Millivolt conversion
    logic [GAIN_W-1:0] gain_sel;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MV_W-1:0]   avg_mv_reg, avg_mv_next;
    logic [MV_W-1:0]   prod_mv;

    // Result register
    logic                   res_valid_reg, res_valid_next;
    logic                   res_load;
    logic [SRC_W-1:0]       res_src_reg;
    logic                   res_att_reg;
    logic [SAMPLE_BITS-1:0] res_lat_reg;
    logic [AVG_W-1:0]       res_avg_reg;
    logic [MV_W-1:0]        res_avg_mv_reg;
    logic [MV_W-1:0]        res_lat_mv_reg;
    logic                   res_fresh_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_gidx  = GIDX_W'(cfg.index - REG_GAIN_0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            for (int g = 0; g < NUM_GAINS; g++)
            begin
                gain_reg[g] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SOURCE_ENABLE)
            begin
                enable_reg <= cfg.data[EN_W-1:0];
            end
            else if (cfg.index >= REG_GAIN_0 && cfg.index <= REG_GAIN_3)
            begin
                gain_reg[cfg_gidx] <= cfg.data[GAIN_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Item intake and memory read
    // ------------------------------------------------------------------
    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign item_vidx  = ({1'b0, item.source_idx} < (SRC_W + 1)'(NUM_SOURCES));

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            mode_reg    <= item.mode;
            src_reg     <= item.source_idx;
            smp_reg     <= item.sample;
            vidx_reg    <= item_vidx;
            on_reg      <= item_vidx && enable_reg[item.source_idx];
            rd_data_reg <= mem[item.source_idx[IDX_W-1:0]];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (item_acc)
            begin
                rd_hit_reg <= item_vidx && ent_valid_reg[item.source_idx[IDX_W-1:0]];
            end
            if (mem_we)
            begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // never-written entries read as zero
    assign cur_lat  = rd_hit_reg ? rd_data_reg[ENT_W-1 -: SAMPLE_BITS] : '0;
    assign cur_sum  = rd_hit_reg ? rd_data_reg[SUM_W+CNT_W+AVG_W-1 -: SUM_W] : '0;
    assign cur_cnt  = rd_hit_reg ? rd_data_reg[CNT_W+AVG_W-1 -: CNT_W] : '0;
    assign cur_held = rd_hit_reg ? rd_data_reg[AVG_W-1:0] : '0;

    assign sum_add  = cur_sum + (SUM_W'(smp_reg) << SUM_FRAC);
    assign cnt_inc  = cur_cnt + CNT_W'(1);
    assign roll     = (cnt_inc == ROLL_COUNT);

    assign wr_addr   = src_reg[IDX_W-1:0];
    assign mem_wdata = {lat_next, sum_next, cnt_next, held_next};

    // ------------------------------------------------------------------
    // Divider and multiplier datapath
    // ------------------------------------------------------------------
    asa_divider #(
        .N (SUM_W),
        .D (DIVR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cur_sum),
        .divisor  ({cur_cnt, (SUM_FRAC - AVG_FRAC)'(0)}),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_sat  = (|div_quo[SUM_W-1:AVG_W]) ? '1 : div_quo[AVG_W-1:0];
    assign gain_sel = gain_reg[src_reg];
    assign prod_mv  = (|prod_reg[PROD_W-1:MV_SHIFT+MV_W]) ? '1
                                                          : prod_reg[MV_SHIFT+MV_W-1:MV_SHIFT];
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || result.ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        lat_next       = lat_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        fresh_next     = fresh_reg;
        prod_next      = prod_reg;
        avg_mv_next    = avg_mv_reg;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        res_valid_next = res_valid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    fresh_next = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                lat_next   = cur_lat;
                sum_next   = cur_sum;
                cnt_next   = cur_cnt;
                held_next  = cur_held;
                state_next = S_MUL_AVG;
                case (mode_reg)
                    MODE_CLEAR:
                    begin
                        if (vidx_reg)
                        begin
                            lat_next  = '0;
                            sum_next  = '0;
                            cnt_next  = '0;
                            held_next = '0;
                            mem_we    = 1'b1;
                        end
                    end
                    MODE_SAMPLE:
                    begin
                        if (on_reg)
                        begin
                            lat_next = smp_reg;
                            // halve at the roll point so the average keeps rolling
                            sum_next = roll ? (sum_add >> 1) : sum_add;
                            cnt_next = roll ? (cnt_inc >> 1) : cnt_inc;
                            mem_we   = 1'b1;
                        end
                    end
                    MODE_READ:
                    begin
                        if (on_reg && cur_cnt != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                held_next  = quo_sat;
                sum_next   = '0;
                cnt_next   = '0;
                fresh_next = 1'b1;
                mem_we     = 1'b1;
                state_next = S_MUL_AVG;
            end
            S_MUL_AVG:
            begin
                prod_next  = PROD_W'(held_reg) * PROD_W'(gain_sel);
                state_next = S_MUL_LAT;
            end
            S_MUL_LAT:
            begin
                avg_mv_next = prod_mv;
                prod_next   = PROD_W'({lat_reg, AVG_FRAC'(0)}) * PROD_W'(gain_sel);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_reg    <= lat_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        held_reg   <= held_next;
        fresh_reg  <= fresh_next;
        prod_reg   <= prod_next;
        avg_mv_reg <= avg_mv_next;
        if (res_load)
        begin
            res_src_reg    <= src_reg;
            res_att_reg    <= on_reg;
            res_lat_reg    <= on_reg ? lat_reg : '0;
            res_avg_reg    <= on_reg ? held_reg : '0;
            res_avg_mv_reg <= on_reg ? avg_mv_reg : '0;
            res_lat_mv_reg <= on_reg ? prod_mv : '0;
            res_fresh_reg  <= on_reg && fresh_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.source_out    = res_src_reg;
    assign result.attached      = res_att_reg;
    assign result.latest_sample = res_lat_reg;
    assign result.average       = res_avg_reg;
    assign result.average_mv    = res_avg_mv_reg;
    assign result.latest_mv     = res_lat_mv_reg;
    assign result.fresh         = res_fresh_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("state memory written while idle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_count_below_roll: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (cnt_next < ROLL_COUNT))
        else $error("stored count reached the roll point");

    a_store_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> (mode_reg == MODE_READ && on_reg && $past(div_done)))
        else $error("average stored without a finished read divide");
`endif

endmodule
